>>> sv/pfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_pkg
// shared constants and types of the pose frame parser
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int unsigned FRAME_LEN   = 14;
    localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
    localparam int unsigned POS_W       = $clog2(FRAME_LEN);
    localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [7:0]  FRAME_HEAD  = 8'hFA;
    localparam logic [7:0]  FRAME_TAIL  = 8'hAB;
    localparam logic [23:0] YAW_LIMIT   = 24'd1800;
    localparam logic [31:0] MAX_AGE_RST = 32'd500;

    // byte offsets of the sign bytes inside a frame
    localparam int unsigned X_OFS   = 1;
    localparam int unsigned Y_OFS   = 5;
    localparam int unsigned YAW_OFS = 9;

    typedef enum logic [1:0] {
        ST_ABSORB = 2'd0,
        ST_GOOD   = 2'd1,
        ST_BAD    = 2'd2
    } t_frame_status;

    typedef logic [7:0] t_frame_bytes [STORE_DEPTH];

    typedef struct packed {
        logic               good;
        logic signed [24:0] x;
        logic signed [24:0] y;
        logic signed [11:0] yaw;
    } t_frame_chk;

endpackage

`default_nettype wire

>>> sv/pfp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_in_if
// byte channel into the pose frame parser
// ----------------------------------------------------------------------------
interface pfp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;

    modport source (output valid, rx_byte, now_ms, input ready);
    modport sink   (input valid, rx_byte, now_ms, output ready);
endinterface

`default_nettype wire

>>> sv/pfp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_out_if
// result channel out of the pose frame parser
// ----------------------------------------------------------------------------
interface pfp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic signed [24:0] pose_x_cm;
    logic signed [24:0] pose_y_cm;
    logic signed [11:0] pose_yaw_tenths;
    logic               pose_valid;
    logic               pose_fresh;
    logic [31:0]        bytes_seen;
    logic [31:0]        heads_seen;
    logic [31:0]        good_frames;
    logic [31:0]        bad_frames;

    modport source (output valid, frame_status, pose_x_cm, pose_y_cm, pose_yaw_tenths,
                    pose_valid, pose_fresh, bytes_seen, heads_seen, good_frames,
                    bad_frames, input ready);
    modport sink   (input valid, frame_status, pose_x_cm, pose_y_cm, pose_yaw_tenths,
                    pose_valid, pose_fresh, bytes_seen, heads_seen, good_frames,
                    bad_frames, output ready);
endinterface

`default_nettype wire

>>> sv/pfp_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_cfg_if
// configuration write channel for the max age register
// ----------------------------------------------------------------------------
interface pfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_age_ms;

    modport source (output valid, max_age_ms, input ready);
    modport sink   (input valid, max_age_ms, output ready);
endinterface

`default_nettype wire

>>> sv/pose_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pose_frame_parser
// assembles 14-byte pose frames from a serial byte stream
// ----------------------------------------------------------------------------
// usage:
//   i_in   one transfer per received byte, with its millisecond timestamp
//   o_out  one transfer per input byte: frame status, latched pose, pose
//          valid/fresh flags and four wrapping 32-bit counters
//   i_cfg  writes max_age_ms (reset 500); always ready, write only while idle
// result: registered, presented in the cycle after its byte transfer
// throughput: one byte per cycle while the receiver takes each result; all
//   parsing is a single combinational pass from the state registers to the result register
// stall: the result register frees when o_out.ready is high, so i_in.ready
//   is low only while a result is held and the receiver stalls
// reset (i_rst_n low, synchronous): hunting for a head byte, pose cleared and
//   not valid, counters zero, max age back to 500
// frame: head 0xFA, three sign+24-bit magnitude groups, tail 0xAB; a rejected
//   frame's final byte restarts the hunt and may open a new frame
// ----------------------------------------------------------------------------
module pose_frame_parser (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfp_in_if.sink    i_in,
    pfp_cfg_if.sink   i_cfg,
    pfp_out_if.source o_out
);
    import pfp_pkg::*;

    // frame store, entries written once per frame before they are read
    t_frame_bytes       r_frame;
    logic [POS_W-1:0]   r_pos,       n_pos;
    logic signed [24:0] r_x_latch;
    logic signed [24:0] r_y_latch;
    logic signed [11:0] r_yaw_latch;
    logic [31:0]        r_last_time;
    logic               r_valid;
    logic [31:0]        r_byte_cnt;
    logic [31:0]        r_head_cnt,  n_head_cnt;
    logic [31:0]        r_good_cnt;
    logic [31:0]        r_bad_cnt,   n_bad_cnt;
    logic [31:0]        r_max_age;

    // result register
    logic               r_out_valid;
    t_frame_status      r_status,    n_status;
    logic               r_fresh,     n_fresh;

    logic               w_in_xfer;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_idx;
    logic               w_is_head;
    logic               w_latch;
    logic [31:0]        w_age;
    t_frame_chk         w_chk;

    pfp_frame_check u_check (
        .i_frame (r_frame),
        .i_tail  (i_in.rx_byte),
        .o_chk   (w_chk)
    );

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_is_head   = (i_in.rx_byte == FRAME_HEAD);
    assign w_age       = i_in.now_ms - r_last_time;

    // byte-level parse step
    always_comb begin
        n_pos      = r_pos;
        n_head_cnt = r_head_cnt;
        n_bad_cnt  = r_bad_cnt;
        n_status   = ST_ABSORB;
        w_wr_en    = 1'b0;
        w_wr_idx   = '0;
        w_latch    = 1'b0;
        if (r_pos == '0) begin
            // hunting: only a head byte opens a frame
            if (w_is_head) begin
                w_wr_en    = 1'b1;
                n_pos      = POS_W'(1);
                n_head_cnt = r_head_cnt + 32'd1;
            end
        end else if (r_pos != POS_W'(FRAME_LEN - 1)) begin
            w_wr_en  = 1'b1;
            w_wr_idx = r_pos;
            n_pos    = r_pos + POS_W'(1);
        end else if (w_chk.good) begin
            // tail byte of an accepted frame, next byte hunts
            w_latch  = 1'b1;
            n_pos    = '0;
            n_status = ST_GOOD;
        end else begin
            // rejected frame, final byte restarts the hunt
            n_status  = ST_BAD;
            n_bad_cnt = r_bad_cnt + 32'd1;
            n_pos     = '0;
            if (w_is_head) begin
                w_wr_en    = 1'b1;
                n_pos      = POS_W'(1);
                n_head_cnt = r_head_cnt + 32'd1;
            end
        end
    end

    // a frame accepted now has age zero, always within any max age
    assign n_fresh = w_latch || (r_valid && (w_age <= r_max_age));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_x_latch   <= '0;
            r_y_latch   <= '0;
            r_yaw_latch <= '0;
            r_last_time <= '0;
            r_valid     <= 1'b0;
            r_byte_cnt  <= '0;
            r_head_cnt  <= '0;
            r_good_cnt  <= '0;
            r_bad_cnt   <= '0;
        end else if (w_in_xfer) begin
            r_pos      <= n_pos;
            r_byte_cnt <= r_byte_cnt + 32'd1;
            r_head_cnt <= n_head_cnt;
            r_bad_cnt  <= n_bad_cnt;
            if (w_latch) begin
                r_x_latch   <= w_chk.x;
                r_y_latch   <= w_chk.y;
                r_yaw_latch <= w_chk.yaw;
                r_last_time <= i_in.now_ms;
                r_valid     <= 1'b1;
                r_good_cnt  <= r_good_cnt + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_wr_en) begin
            r_frame[w_wr_idx] <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= MAX_AGE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_age <= i_cfg.max_age_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_status <= n_status;
            r_fresh  <= n_fresh;
        end
    end

    // pose and counters change only on a byte transfer, which also loads the
    // result register, so they are presented straight from the state
    assign o_out.valid           = r_out_valid;
    assign o_out.frame_status    = r_status;
    assign o_out.pose_x_cm       = r_x_latch;
    assign o_out.pose_y_cm       = r_y_latch;
    assign o_out.pose_yaw_tenths = r_yaw_latch;
    assign o_out.pose_valid      = r_valid;
    assign o_out.pose_fresh      = r_fresh;
    assign o_out.bytes_seen      = r_byte_cnt;
    assign o_out.heads_seen      = r_head_cnt;
    assign o_out.good_frames     = r_good_cnt;
    assign o_out.bad_frames      = r_bad_cnt;

endmodule

`default_nettype wire

>>> sv/pfp_frame_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_frame_check
// validates a complete frame and decodes its sign/magnitude groups
// ----------------------------------------------------------------------------
module pfp_frame_check (
    input  pfp_pkg::t_frame_bytes i_frame,
    input  wire logic [7:0]       i_tail,
    output pfp_pkg::t_frame_chk   o_chk
);
    import pfp_pkg::*;

    logic [23:0] w_x_mag;
    logic [23:0] w_y_mag;
    logic [23:0] w_yaw_mag;
    logic        w_sign_ok;
    logic        w_frame_ok;

    assign w_x_mag   = {i_frame[X_OFS+1], i_frame[X_OFS+2], i_frame[X_OFS+3]};
    assign w_y_mag   = {i_frame[Y_OFS+1], i_frame[Y_OFS+2], i_frame[Y_OFS+3]};
    assign w_yaw_mag = {i_frame[YAW_OFS+1], i_frame[YAW_OFS+2], i_frame[YAW_OFS+3]};

    // sign bytes must be 0 or 1
    assign w_sign_ok = (i_frame[X_OFS][7:1] == 7'd0) && (i_frame[Y_OFS][7:1] == 7'd0)
                    && (i_frame[YAW_OFS][7:1] == 7'd0);
    assign w_frame_ok = (i_frame[0] == FRAME_HEAD) && (i_tail == FRAME_TAIL) && w_sign_ok;

    always_comb begin
        // yaw window is symmetric, so only the magnitude matters
        o_chk.good = w_frame_ok && (w_yaw_mag <= YAW_LIMIT);
        o_chk.x    = i_frame[X_OFS][0] ? -$signed({1'b0, w_x_mag}) : $signed({1'b0, w_x_mag});
        o_chk.y    = i_frame[Y_OFS][0] ? -$signed({1'b0, w_y_mag}) : $signed({1'b0, w_y_mag});
        o_chk.yaw  = i_frame[YAW_OFS][0] ? -$signed({1'b0, w_yaw_mag[10:0]})
                                         : $signed({1'b0, w_yaw_mag[10:0]});
    end

endmodule

`default_nettype wire

>>> test/pose_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_frame_parser_tb
// self-checking bench for the pose frame parser: byte streams of well-formed
// and broken frames go in, every result is checked against a pose tracker
// that mirrors the parser state, under several max age settings
// ----------------------------------------------------------------------------
module pose_frame_parser_tb;
    import pfp_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;   // cycles without any transfer
    localparam int unsigned HOLD_CYCLES = 60;     // long receiver hold-off

    // one result as the parser reports it
    typedef struct packed {
        t_frame_status      status;
        logic signed [24:0] x_cm;
        logic signed [24:0] y_cm;
        logic signed [11:0] yaw_tenths;
        logic               valid;
        logic               fresh;
        logic [31:0]        bytes;
        logic [31:0]        heads;
        logic [31:0]        good;
        logic [31:0]        bad;
    } t_pose_report;

    // ------------------------------------------------------------------------
    // pose tracker: follows the byte stream, predicts each report and checks
    // the reports that come back in order
    // ------------------------------------------------------------------------
    class pose_tracker;
        logic [31:0]        max_age;
        logic [7:0]         frame_buf [FRAME_LEN];
        int unsigned        fill;
        logic signed [24:0] x_cm;
        logic signed [24:0] y_cm;
        logic signed [11:0] yaw_tenths;
        logic [31:0]        last_fix_ms;
        logic               have_fix;
        logic [31:0]        n_bytes;
        logic [31:0]        n_heads;
        logic [31:0]        n_good;
        logic [31:0]        n_bad;
        int unsigned        errors;
        t_pose_report       pending_reports [$];

        function new();
            max_age     = MAX_AGE_RST;
            foreach (frame_buf[i]) frame_buf[i] = 8'h00;
            fill        = 0;
            x_cm        = '0;
            y_cm        = '0;
            yaw_tenths  = '0;
            last_fix_ms = '0;
            have_fix    = 1'b0;
            n_bytes     = '0;
            n_heads     = '0;
            n_good      = '0;
            n_bad       = '0;
            errors      = 0;
        endfunction

        // hunt for a head byte; a head starts a new frame
        function void hunt(logic [7:0] b);
            fill = 0;
            if (b == FRAME_HEAD) begin
                frame_buf[0] = b;
                fill = 1;
                n_heads++;
            end
        endfunction

        // sign byte at ofs, then 24-bit big-endian magnitude
        function int group_value(int unsigned ofs);
            int mag;
            mag = int'({8'h00, frame_buf[ofs + 1], frame_buf[ofs + 2], frame_buf[ofs + 3]});
            return (frame_buf[ofs] != 8'h00) ? -mag : mag;
        endfunction

        // note one accepted byte and queue the report it must produce
        function void absorb_byte(logic [7:0] b, logic [31:0] now);
            t_pose_report  r;
            t_frame_status st;
            int            x;
            int            y;
            int            yaw;
            int            lim;
            logic [31:0]   age;
            st  = ST_ABSORB;
            lim = int'(YAW_LIMIT);
            n_bytes++;
            if (fill == 0) begin
                hunt(b);
            end else begin
                frame_buf[fill] = b;
                fill++;
                if (fill == FRAME_LEN) begin
                    x   = group_value(X_OFS);
                    y   = group_value(Y_OFS);
                    yaw = group_value(YAW_OFS);
                    if (frame_buf[FRAME_LEN - 1] != FRAME_TAIL || frame_buf[X_OFS] > 8'd1 ||
                        frame_buf[Y_OFS] > 8'd1 || frame_buf[YAW_OFS] > 8'd1 ||
                        yaw > lim || yaw < -lim) begin
                        // rejected: the closing byte goes back to the hunt
                        n_bad++;
                        hunt(b);
                        st = ST_BAD;
                    end else begin
                        x_cm        = x[24:0];
                        y_cm        = y[24:0];
                        yaw_tenths  = yaw[11:0];
                        last_fix_ms = now;
                        have_fix    = 1'b1;
                        n_good++;
                        fill        = 0;
                        st          = ST_GOOD;
                    end
                end
            end
            age          = now - last_fix_ms;
            r.status     = st;
            r.x_cm       = x_cm;
            r.y_cm       = y_cm;
            r.yaw_tenths = yaw_tenths;
            r.valid      = have_fix;
            r.fresh      = have_fix && (age <= max_age);
            r.bytes      = n_bytes;
            r.heads      = n_heads;
            r.good       = n_good;
            r.bad        = n_bad;
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
                errors++;
            end
        endfunction

        // check one accepted report against the oldest prediction
        function void match_report(t_pose_report got);
            t_pose_report want;
            if (pending_reports.size() == 0) begin
                $error("report transfer with no byte outstanding");
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("frame_status", want.status, got.status);
            compare_field("pose_x_cm", want.x_cm, got.x_cm);
            compare_field("pose_y_cm", want.y_cm, got.y_cm);
            compare_field("pose_yaw_tenths", want.yaw_tenths, got.yaw_tenths);
            compare_field("pose_valid", want.valid, got.valid);
            compare_field("pose_fresh", want.fresh, got.fresh);
            compare_field("bytes_seen", want.bytes, got.bytes);
            compare_field("heads_seen", want.heads, got.heads);
            compare_field("good_frames", want.good, got.good);
            compare_field("bad_frames", want.bad, got.bad);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the parser
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #2 i_clk = ~i_clk;

    pfp_in_if  in_ch ();
    pfp_out_if out_ch ();
    pfp_cfg_if cfg_ch ();

    pose_frame_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    pose_tracker  tracker;
    t_pose_report seen_report;

    // stimulus knobs, changed per phase
    logic        in_gappy  = 1'b1;   // sender idles at random
    logic        out_gappy = 1'b1;   // receiver stalls at random
    int unsigned hold_len  = 0;      // pending receiver hold-off, in cycles
    logic [31:0] clock_ms  = '0;     // timestamp sent with the next byte
    int unsigned ms_step_max = 5;    // largest time step between bytes

    // ------------------------------------------------------------------------
    // receiver side: ready changes on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_len != 0) begin
            // long hold-off so the parser fills up and stalls its input
            hold_len = hold_len - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(out_gappy && $urandom_range(99) < 29);
        end
    end

    // report monitor: sample on the rising edge, check every transfer
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            seen_report.status     = t_frame_status'(out_ch.frame_status);
            seen_report.x_cm       = out_ch.pose_x_cm;
            seen_report.y_cm       = out_ch.pose_y_cm;
            seen_report.yaw_tenths = out_ch.pose_yaw_tenths;
            seen_report.valid      = out_ch.pose_valid;
            seen_report.fresh      = out_ch.pose_fresh;
            seen_report.bytes      = out_ch.bytes_seen;
            seen_report.heads      = out_ch.heads_seen;
            seen_report.good       = out_ch.good_frames;
            seen_report.bad        = out_ch.bad_frames;
            tracker.match_report(seen_report);
        end
    end

    // watchdog: too long without any transfer ends the run
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers: all called and returning on a falling edge
    // ------------------------------------------------------------------------

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while (in_gappy && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        if (ms_step_max != 0) begin
            clock_ms = clock_ms + 32'($urandom_range(ms_step_max));
            // rare jump anywhere on the time line
            if ($urandom_range(199) == 0) clock_ms = $urandom();
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.now_ms  <= clock_ms;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.absorb_byte(b, clock_ms);
        @(negedge i_clk);
    endtask

    // head (optional), three sign/magnitude groups, tail
    task automatic send_frame(input logic with_head,
                              input logic [7:0] xs, input logic [23:0] xm,
                              input logic [7:0] ys, input logic [23:0] ym,
                              input logic [7:0] ws, input logic [23:0] wm,
                              input logic [7:0] tail);
        logic [103:0] body;
        body = {xs, xm, ys, ym, ws, wm, tail};
        if (with_head) send_byte(FRAME_HEAD);
        for (int i = 12; i >= 0; i--) send_byte(body[i * 8 +: 8]);
    endtask

    // max age write, only while the parser is idle
    task automatic write_max_age(input logic [31:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.max_age_ms <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.max_age = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending and wait for every outstanding report
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic logic [23:0] pick_mag();
        case ($urandom_range(9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    // mostly well-formed frames with random content, plus broken ones and noise
    task automatic random_traffic(input int unsigned n);
        logic [31:0] start;
        int unsigned kind;
        logic [7:0]  xs;
        logic [7:0]  ys;
        logic [7:0]  ws;
        logic [7:0]  tail;
        logic [23:0] xm;
        logic [23:0] ym;
        logic [23:0] wm;
        start = tracker.n_bytes;
        while (tracker.n_bytes - start < n) begin
            kind = $urandom_range(99);
            xs   = 8'($urandom_range(1));
            ys   = 8'($urandom_range(1));
            ws   = 8'($urandom_range(1));
            xm   = pick_mag();
            ym   = pick_mag();
            wm   = ($urandom_range(9) == 0) ? 24'd1800 : 24'($urandom_range(1800));
            tail = FRAME_TAIL;
            if (kind < 72) begin
                // well formed
            end else if (kind < 80) begin
                wm = 24'($urandom_range(24'hFFFFFF, 1801));
            end else if (kind < 87) begin
                case ($urandom_range(2))
                    0:       xs = 8'($urandom_range(255, 2));
                    1:       ys = 8'($urandom_range(255, 2));
                    default: ws = 8'($urandom_range(255, 2));
                endcase
            end else if (kind < 93) begin
                tail = $urandom_range(1) ? FRAME_HEAD : 8'($urandom_range(255));
            end
            if (kind < 93) begin
                send_frame(1'b1, xs, xm, ys, ym, ws, wm, tail);
            end else begin
                repeat ($urandom_range(20, 1)) send_byte(8'($urandom_range(255)));
            end
            // line noise between frames now and then
            if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = '0;
        in_ch.now_ms      = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.max_age_ms = '0;
        out_ch.ready      = 1'b0;
        i_rst_n           = 1'b0;
        tracker           = new();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, default max age of 500
        // bytes other than a head are ignored while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(FRAME_TAIL);
        // largest magnitudes, yaw on the upper limit
        send_frame(1'b1, 8'd0, 24'hFFFFFF, 8'd1, 24'hFFFFFF, 8'd0, 24'd1800, FRAME_TAIL);
        // negative zero for X, yaw on the lower limit
        send_frame(1'b1, 8'd1, 24'h000000, 8'd0, 24'h000000, 8'd1, 24'd1800, FRAME_TAIL);
        // pose age exactly at the limit, then one past it
        ms_step_max = 0;
        clock_ms = tracker.last_fix_ms + 32'd500;
        send_byte(8'h00);
        clock_ms = clock_ms + 32'd1;
        send_byte(8'h00);
        ms_step_max = 5;
        // yaw just past the limit, and far below it
        send_frame(1'b1, 8'd0, 24'h000001, 8'd0, 24'h000002, 8'd0, 24'd1801, FRAME_TAIL);
        send_frame(1'b1, 8'd0, 24'h000000, 8'd0, 24'h000000, 8'd1, 24'hFFFFFF, FRAME_TAIL);
        // sign bytes above one in each group
        send_frame(1'b1, 8'h02, 24'h000001, 8'd0, 24'h000001, 8'd0, 24'h000001, FRAME_TAIL);
        send_frame(1'b1, 8'd0, 24'h000001, 8'hFF, 24'h000001, 8'd0, 24'h000001, FRAME_TAIL);
        send_frame(1'b1, 8'd0, 24'h000001, 8'd0, 24'h000001, 8'h80, 24'h000001, FRAME_TAIL);
        // wrong tail
        send_frame(1'b1, 8'd0, 24'h000001, 8'd0, 24'h000001, 8'd0, 24'h000001, 8'h00);
        // wrong tail that is a head: it opens the next frame, whose body follows
        send_frame(1'b1, 8'd0, 24'h123456, 8'd1, 24'h0ABCDE, 8'd0, 24'd7, FRAME_HEAD);
        send_frame(1'b0, 8'd1, 24'hFAFAFA, 8'd0, 24'hFA00FA, 8'd1, 24'd900, FRAME_TAIL);
        // head bytes inside an accepted frame open nothing; the next byte hunts
        send_byte(8'h55);
        drain();

        // zero max age: fresh only within the same millisecond
        write_max_age(32'd0);
        ms_step_max = 2;
        random_traffic(250);
        drain();

        // largest max age, time running across the wrap
        write_max_age(32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FF00;
        ms_step_max = 8;
        random_traffic(200);
        drain();

        // no idling on either side, with one long receiver hold-off
        in_gappy  = 1'b0;
        out_gappy = 1'b0;
        write_max_age(32'd20);
        ms_step_max = 3;
        hold_len = HOLD_CYCLES;
        random_traffic(400);
        drain();

        // random max age, large time steps
        in_gappy  = 1'b1;
        out_gappy = 1'b1;
        write_max_age(32'($urandom_range(2000, 1)));
        ms_step_max = 300;
        random_traffic(350);
        drain();

        // small max age with the pose age crossing the time wrap
        write_max_age(32'd30);
        clock_ms = 32'hFFFF_FFF0;
        ms_step_max = 3;
        random_traffic(350);
        drain();

        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
